// File: src/dtq_pkg.sv
// Shared types and constants of the deadline timer queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package dtq_pkg;

    localparam logic [1:0] OP_ARM_MS = 2'd0;
    localparam logic [1:0] OP_ARM_US = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam int US_PER_MS  = 1000;
    localparam int MAX_EXPIRE = 32;

    // x / 1000 = (x >> 3) / 125; ceil(2^47 / 125) is exact for 40-bit dividends
    localparam int          RECIP_SHIFT = 47;
    localparam logic [40:0] RECIP_125   = 41'd1125899906843;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  slot;
        logic [31:0] delay;
        logic        cancelable;
        logic [31:0] now_msec;
        logic [63:0] now_usec;
    } t_in;

    typedef struct packed {
        logic [4:0]  expired_slot;
        logic        expired_flag;
        logic [31:0] nearest_ms;
        logic [63:0] nearest_us;
        logic [31:0] timeout_ms;
        logic        only_cancelable;
        logic        last;
    } t_out;

    typedef struct packed {
        logic load;
        logic arm;
        logic scan_init;
        logic step;
        logic next_kind;
        logic emit_slot;
        logic emit_close;
        logic emit_query;
        logic div_init;
        logic div_step;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       scan_last;
        logic       found;
        logic       count_full;
        logic       kind;
        logic       div_last;
        logic       out_free;
    } t_sts;

endpackage

// File: src/dtq_ctrl.sv
// Controller of the deadline timer queue: sequences arming, scans, emits and the divide.
// Depends on dtq_pkg; drives the datapath through t_cmd and reads t_sts.
module dtq_ctrl import dtq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_op,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_DRAIN  = 8'b0000_0100,
        S_PICK   = 8'b0000_1000,
        S_EMIT   = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_REPORT = 8'b0100_0000,
        S_CLOSE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_op == OP_ARM_MS || i_in_op == OP_ARM_US) begin
                        o_cmd.arm = 1'b1;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_sts.op == OP_QUERY) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (i_sts.count_full) begin
                    n_state = S_CLOSE;
                end else if (i_sts.found) begin
                    n_state = S_EMIT;
                end else if (!i_sts.kind) begin
                    // ms timers exhausted, go on with precise timers
                    o_cmd.next_kind = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    n_state = S_CLOSE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_slot = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_REPORT;
            end
            S_REPORT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_query = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_CLOSE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_close = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/dtq_dp.sv
// Datapath of the deadline timer queue: deadline memory, slot flags, scan compare,
// divide by 1000 and the output register. Depends on dtq_pkg; commanded by dtq_ctrl.
module dtq_dp import dtq_pkg::*; #(
    parameter int TIMERS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in_data,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_out o_out_data
);

    localparam int SW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

    logic [63:0]       r_mem [TIMERS];
    logic [TIMERS-1:0] r_armed, r_prec, r_canc;

    t_in         r_in;
    logic [SW-1:0] r_idx, r_rd_idx, r_best_idx;
    logic [63:0] r_rd_data;
    logic        r_rd_vld;
    logic        r_found;
    logic [63:0] r_best_key;
    logic        r_kind;
    logic [5:0]  r_n;
    logic        r_have_ms, r_have_us, r_only_c;
    logic [31:0] r_ms_best;
    logic [63:0] r_us_best;
    logic [39:0] r_t;
    logic        r_big;
    logic [80:0] r_acc;
    logic        r_div_cnt;
    logic        r_out_vld;
    t_out        r_out;

    logic          w_slot_ok;
    logic [SW-1:0] w_slot_idx;
    logic [63:0]   w_arm_dl;
    logic          w_armed, w_prec, w_canc;
    logic [31:0]   w_d_ms;
    logic [63:0]   w_d_us, w_d64;
    logic          w_due, w_better;
    logic [63:0]   w_rem_us;
    logic [31:0]   w_rem_ms;
    logic [63:0]   w_us_next;
    logic [42:0]   w_z;
    logic [19:0]   w_half;
    logic [60:0]   w_prod;
    logic [33:0]   w_quo;
    logic [31:0]   w_timeout;
    logic          w_out_free;

    assign w_slot_ok  = (9'(i_in_data.slot) < 9'(TIMERS));
    assign w_slot_idx = SW'(i_in_data.slot);
    assign w_arm_dl   = (i_in_data.op == OP_ARM_US)
                      ? i_in_data.now_usec + 64'(i_in_data.delay)
                      : 64'(i_in_data.now_msec + i_in_data.delay);

    assign w_armed = r_armed[r_rd_idx];
    assign w_prec  = r_prec[r_rd_idx];
    assign w_canc  = r_canc[r_rd_idx];
    assign w_d_ms  = r_rd_data[31:0] - r_in.now_msec;
    assign w_d_us  = r_rd_data - r_in.now_usec;
    // ms differences sign-extended so both kinds order the same way
    assign w_d64   = w_prec ? w_d_us : {{32{w_d_ms[31]}}, w_d_ms};
    assign w_due   = (w_d64 == '0) || w_d64[63];
    assign w_better = r_rd_vld && w_armed && (w_prec == r_kind) && w_due
                   && (!r_found || ($signed(w_d64) < $signed(r_best_key)));
    assign w_rem_us = w_d_us[63] ? '0 : w_d_us;
    assign w_rem_ms = w_d_ms[31] ? '0 : w_d_ms;

    // nearest precise remainder including the entry evaluated this cycle
    assign w_us_next = (r_rd_vld && w_armed && w_prec && (!r_have_us || w_rem_us < r_us_best))
                     ? w_rem_us : r_us_best;

    // ceil(x / 1000) = floor((x + 999) / 1000); only remainders below 2^42 can beat a 32-bit limit
    assign w_z     = {1'b0, w_us_next[41:0]} + 43'(US_PER_MS - 1);
    assign w_half  = r_div_cnt ? r_t[39:20] : r_t[19:0];
    assign w_prod  = 61'(w_half) * 61'(RECIP_125);
    assign w_quo   = r_acc[RECIP_SHIFT +: 34];
    assign w_timeout = (r_have_us && !r_big && (w_quo < 34'(r_in.delay))) ? w_quo[31:0]
                                                                          : r_in.delay;

    assign w_out_free = !r_out_vld || !i_out_stall;

    // deadline memory: one write port for arming, one registered read port for scans
    always_ff @(posedge i_clk) begin
        if (i_cmd.arm && w_slot_ok) r_mem[w_slot_idx] <= w_arm_dl;
        if (i_cmd.step) r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
            r_prec  <= '0;
            r_canc  <= '0;
        end else if (i_cmd.arm && w_slot_ok) begin
            r_armed[w_slot_idx] <= 1'b1;
            r_prec[w_slot_idx]  <= (i_in_data.op == OP_ARM_US);
            r_canc[w_slot_idx]  <= i_in_data.cancelable;
        end else if (i_cmd.emit_slot) begin
            r_armed[r_best_idx] <= 1'b0;
            r_prec[r_best_idx]  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in_data;
        r_rd_idx <= r_idx;
        if (w_better) begin
            r_best_idx <= r_rd_idx;
            r_best_key <= w_d64;
        end
        if (r_rd_vld && w_armed) begin
            if (w_prec && (!r_have_us || w_rem_us < r_us_best)) r_us_best <= w_rem_us;
            if (!w_prec && (!r_have_ms || w_rem_ms < r_ms_best)) r_ms_best <= w_rem_ms;
        end
        if (i_cmd.div_init) begin
            r_t   <= w_z[42:3];
            r_big <= |w_us_next[63:42];
            r_acc <= '0;
        end else if (i_cmd.div_step) begin
            r_acc <= r_acc + (r_div_cnt ? {w_prod, 20'd0} : 81'(w_prod));
        end
        if (i_cmd.emit_slot) begin
            r_out              <= '0;
            r_out.expired_slot <= 5'(r_best_idx);
            r_out.expired_flag <= 1'b1;
        end else if (i_cmd.emit_close) begin
            r_out      <= '0;
            r_out.last <= 1'b1;
        end else if (i_cmd.emit_query) begin
            r_out                 <= '0;
            r_out.nearest_ms      <= r_have_ms ? r_ms_best : '1;
            r_out.nearest_us      <= r_have_us ? r_us_best : '1;
            r_out.timeout_ms      <= w_timeout;
            r_out.only_cancelable <= r_only_c;
            r_out.last            <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_kind    <= 1'b0;
            r_n       <= '0;
            r_have_ms <= 1'b0;
            r_have_us <= 1'b0;
            r_only_c  <= 1'b1;
            r_div_cnt <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
            if (i_cmd.load) begin
                r_kind <= 1'b0;
                r_n    <= '0;
            end
            if (i_cmd.next_kind) r_kind <= 1'b1;
            if (i_cmd.scan_init) begin
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_have_ms <= 1'b0;
                r_have_us <= 1'b0;
                r_only_c  <= 1'b1;
            end else begin
                if (i_cmd.step) begin
                    r_idx <= (r_idx == SW'(TIMERS - 1)) ? '0 : r_idx + 1'b1;
                end
                if (w_better) r_found <= 1'b1;
                if (r_rd_vld && w_armed) begin
                    if (!w_canc) r_only_c <= 1'b0;
                    if (w_prec) r_have_us <= 1'b1;
                    else        r_have_ms <= 1'b1;
                end
            end
            if (i_cmd.emit_slot) r_n <= r_n + 1'b1;
            if (i_cmd.div_init)      r_div_cnt <= 1'b0;
            else if (i_cmd.div_step) r_div_cnt <= ~r_div_cnt;
            if (i_cmd.emit_slot || i_cmd.emit_close || i_cmd.emit_query) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.op         = r_in.op;
    assign o_sts.scan_last  = (r_idx == SW'(TIMERS - 1));
    assign o_sts.found      = r_found;
    assign o_sts.count_full = (r_n == 6'(MAX_EXPIRE));
    assign o_sts.kind       = r_kind;
    assign o_sts.div_last   = (r_div_cnt == 1'b1);
    assign o_sts.out_free   = w_out_free;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: src/deadline_timer_queue.sv
// Channel   Direction  Handshake               Payload
// in        to block   i_in_valid / o_in_stall   i_in_data  (t_in)
// out       from block o_out_valid / i_out_stall o_out_data (t_out)
//
// Arming leaves the block ready for the next transaction.
// Each scan reads the deadline memory one slot a cycle.
// Expire runs up to k + 2 scans for k expired slots, emits each slot found, then a closing result.
// Query runs one scan, then a reciprocal multiply for the divide by 1000, low half then
// high half, then reports.
// Reset is synchronous, active low, and clears all slot flags; no clearing pass.
// The output register holds under stall; a new transaction is taken meanwhile.
module deadline_timer_queue import dtq_pkg::*; #(
    parameter int TIMERS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.op),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    dtq_dp #(.TIMERS(TIMERS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: src/dtq_chk.sv
// Port-level checks of the deadline timer queue, bound to the top level.
// Depends on dtq_pkg and deadline_timer_queue.
module dtq_chk import dtq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_arm_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
        && (i_in_data.op == OP_ARM_MS || i_in_data.op == OP_ARM_US) |=> !o_in_stall)
        else $error("arming did not leave the block ready");

    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall
        && (i_in_data.op == OP_EXPIRE || i_in_data.op == OP_QUERY) |=> o_in_stall)
        else $error("expire or query did not occupy the block");

    a_slot_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.expired_flag && o_out_data.last))
        else $error("expired slot marked as closing result");

endmodule

bind deadline_timer_queue dtq_chk u_dtq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: tb/deadline_timer_queue_tb.sv
// Self-checking testbench of the deadline timer queue: directed table, then random traffic.
// Depends on dtq_pkg and deadline_timer_queue; predicts every result with its own model.
`timescale 1ns / 100ps

module deadline_timer_queue_tb;
    import dtq_pkg::*;

    localparam int SLOTS = 32;
    localparam int STALL_LIMIT = 20000;
    localparam int N_RANDOM = 440;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    deadline_timer_queue dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0] due_at [SLOTS];
    logic [SLOTS-1:0] armed_q, precise_q, cancel_q;
    t_out pending_results[$];
    int errors = 0;
    int n_results = 0;
    int n_items = 0;
    int n_expired = 0;
    int idle_pct = 13;
    int quiet_cycles = 0;
    bit timed_out = 0;

    function automatic bit slot_due(int i, logic [31:0] ms, logic [63:0] us);
        logic [63:0] d64;
        logic [31:0] d32;
        d64 = due_at[i] - us;
        d32 = due_at[i][31:0] - ms;
        if (precise_q[i]) return d64 == 0 || d64[63];
        return d32 == 0 || d32[31];
    endfunction

    function automatic logic [63:0] slot_rank(int i, logic [31:0] ms, logic [63:0] us);
        logic [31:0] d32;
        if (precise_q[i]) return (due_at[i] - us) ^ 64'h8000_0000_0000_0000;
        d32 = (due_at[i][31:0] - ms) ^ 32'h8000_0000;
        return {32'd0, d32};
    endfunction

    task automatic predict_timers(input t_in it);
        t_out r;
        int cnt, best;
        bit found, kind;
        logic [63:0] best_k, k, d64, rem_us, tmo, rnd;
        logic [31:0] d32, rem_ms;
        bit have_ms, have_us, only_c;
        cnt = 0;
        case (it.op)
            OP_ARM_MS, OP_ARM_US: begin
                due_at[it.slot] = (it.op == OP_ARM_MS) ? {32'd0, it.now_msec + it.delay}
                                                       : it.now_usec + {32'd0, it.delay};
                armed_q[it.slot] = 1'b1;
                precise_q[it.slot] = (it.op == OP_ARM_US);
                cancel_q[it.slot] = it.cancelable;
            end
            OP_EXPIRE: begin
                for (int kk = 0; kk < 2; kk++) begin
                    kind = kk[0];
                    while (cnt < MAX_EXPIRE) begin
                        found = 0;
                        best = 0;
                        best_k = '0;
                        for (int i = 0; i < SLOTS; i++) begin
                            if (armed_q[i] && precise_q[i] == kind
                                    && slot_due(i, it.now_msec, it.now_usec)) begin
                                k = slot_rank(i, it.now_msec, it.now_usec);
                                if (!found || k < best_k) begin
                                    found = 1;
                                    best = i;
                                    best_k = k;
                                end
                            end
                        end
                        if (!found) break;
                        armed_q[best] = 1'b0;
                        precise_q[best] = 1'b0;
                        r = '0;
                        r.expired_slot = best[4:0];
                        r.expired_flag = 1'b1;
                        pending_results.push_back(r);
                        cnt++;
                    end
                end
                r = '0;
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            default: begin
                have_ms = 0;
                have_us = 0;
                only_c = 1;
                rem_ms = '0;
                rem_us = '0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (armed_q[i]) begin
                        if (!cancel_q[i]) only_c = 0;
                        if (precise_q[i]) begin
                            d64 = due_at[i] - it.now_usec;
                            if (d64[63]) d64 = '0;
                            if (!have_us || d64 < rem_us) rem_us = d64;
                            have_us = 1;
                        end else begin
                            d32 = due_at[i][31:0] - it.now_msec;
                            if (d32[31]) d32 = '0;
                            if (!have_ms || d32 < rem_ms) rem_ms = d32;
                            have_ms = 1;
                        end
                    end
                end
                tmo = {32'd0, it.delay};
                if (have_us) begin
                    rnd = rem_us / US_PER_MS + ((rem_us % US_PER_MS) != 0);
                    if (rnd < tmo) tmo = rnd;
                end
                r = '0;
                r.nearest_ms = have_ms ? rem_ms : '1;
                r.nearest_us = have_us ? rem_us : '1;
                r.timeout_ms = tmo[31:0];
                r.only_cancelable = only_c;
                r.last = 1'b1;
                pending_results.push_back(r);
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %0h expected %0h", n_results, what, got, want);
    endtask

    // output checker and watchdog
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected", o_out_data.nearest_us, '0);
                end else begin
                    w = pending_results.pop_front();
                    if (w.expired_flag) n_expired++;
                    if (o_out_data.expired_slot != w.expired_slot)
                        report_mismatch("expired_slot", 64'(o_out_data.expired_slot),
                                        64'(w.expired_slot));
                    if (o_out_data.expired_flag != w.expired_flag)
                        report_mismatch("expired_flag", 64'(o_out_data.expired_flag),
                                        64'(w.expired_flag));
                    if (o_out_data.nearest_ms != w.nearest_ms)
                        report_mismatch("nearest_ms", 64'(o_out_data.nearest_ms),
                                        64'(w.nearest_ms));
                    if (o_out_data.nearest_us != w.nearest_us)
                        report_mismatch("nearest_us", o_out_data.nearest_us, w.nearest_us);
                    if (o_out_data.timeout_ms != w.timeout_ms)
                        report_mismatch("timeout_ms", 64'(o_out_data.timeout_ms),
                                        64'(w.timeout_ms));
                    if (o_out_data.only_cancelable != w.only_cancelable)
                        report_mismatch("only_cancelable", 64'(o_out_data.only_cancelable),
                                        64'(w.only_cancelable));
                    if (o_out_data.last != w.last)
                        report_mismatch("last", 64'(o_out_data.last), 64'(w.last));
                end
            end
            i_out_stall <= ($urandom_range(99) < idle_pct);
            if (quiet_cycles > STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("deadline_timer_queue_tb failed");
                $finish;
            end
        end
    end

    // present one transaction, idle at random before it, and wait for acceptance
    task automatic send_item(input t_in it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_timers(it);
        n_items++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_in make_item(input logic [1:0] op, input logic [4:0] slot,
                                      input logic [31:0] dly, input logic canc,
                                      input logic [31:0] ms, input logic [63:0] us);
        t_in it;
        it.op = op;
        it.slot = slot;
        it.delay = dly;
        it.cancelable = canc;
        it.now_msec = ms;
        it.now_usec = us;
        return it;
    endfunction

    // directed rows; a row with has_exp carries a result readable at a glance
    typedef struct {
        t_in item;
        bit has_exp;
        t_out want;
    } t_row;

    t_row rows[$];

    task automatic add_row(input t_in it, input bit has_exp, input t_out want);
        t_row r;
        r.item = it;
        r.has_exp = has_exp;
        r.want = want;
        rows.push_back(r);
    endtask

    initial begin
        t_in it;
        t_out w;
        logic [31:0] ms_now;
        logic [63:0] us_now;
        int pick;

        armed_q = '0;
        precise_q = '0;
        cancel_q = '0;
        for (int i = 0; i < SLOTS; i++) due_at[i] = '0;

        // empty queue: query gives all ones and the untouched wait limit
        w = '0;
        w.nearest_ms = '1;
        w.nearest_us = '1;
        w.timeout_ms = '1;
        w.only_cancelable = 1'b1;
        w.last = 1'b1;
        add_row(make_item(OP_QUERY, 5'd0, 32'hFFFF_FFFF, 1'b0, '0, '0), 1, w);
        w = '0;
        w.last = 1'b1;
        add_row(make_item(OP_EXPIRE, 5'd31, '1, 1'b1, '1, '1), 1, w);
        // extremes, wrap, ties, precise remainder rounding
        add_row(make_item(OP_ARM_MS, 5'd0, 32'd0, 1'b1, 32'hFFFF_FFF0, '0), 0, '0);
        add_row(make_item(OP_ARM_MS, 5'd31, 32'h7FFF_FFFF, 1'b0, 32'hFFFF_FFFF, '0), 0, '0);
        add_row(make_item(OP_ARM_MS, 5'd5, 32'h20, 1'b1, 32'hFFFF_FFF0, '0), 0, '0);
        add_row(make_item(OP_ARM_MS, 5'd3, 32'h20, 1'b1, 32'hFFFF_FFF0, '0), 0, '0);
        add_row(make_item(OP_ARM_US, 5'd7, 32'd1001, 1'b1, '0, 64'hFFFF_FFFF_FFFF_FF00), 0, '0);
        add_row(make_item(OP_ARM_US, 5'd8, 32'hFFFF_FFFF, 1'b0, '0, 64'hFFFF_FFFF_0000_0000),
                0, '0);
        add_row(make_item(OP_QUERY, 5'd0, 32'd5, 1'b0, 32'hFFFF_FFF0,
                          64'hFFFF_FFFF_FFFF_FF00), 0, '0);
        add_row(make_item(OP_QUERY, 5'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFF8,
                          64'hFFFF_FFFF_FFFF_FF00), 0, '0);
        add_row(make_item(OP_EXPIRE, 5'd0, '0, 1'b0, 32'h10, 64'h0000_0000_0000_0300), 0, '0);
        // re-arm replaces, then cancelable-only state
        add_row(make_item(OP_ARM_US, 5'd31, 32'd0, 1'b1, '0, 64'h1234), 0, '0);
        add_row(make_item(OP_QUERY, 5'd0, 32'd0, 1'b0, '0, 64'h1234), 0, '0);
        add_row(make_item(OP_EXPIRE, 5'd0, '0, 1'b0, 32'h7FFF_0000, 64'h7FFF_FFFF_FFFF_FFFF),
                0, '0);
        add_row(make_item(OP_QUERY, 5'd0, 32'd77, 1'b0, '0, '0), 0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_item(rows[i].item);
            if (rows[i].has_exp && pending_results.size() != 0
                    && pending_results[$] != rows[i].want)
                report_mismatch("directed row", 64'(i), '0);
        end
        drain_results();

        // random traffic: a clock advancing mostly forward, near-term deadlines
        ms_now = $urandom;
        us_now = {$urandom, $urandom};
        for (int n = 0; n < N_RANDOM; n++) begin
            idle_pct = (n >= 150 && n < 230) ? 0 : 13;
            if (n == 300) drain_results();
            pick = $urandom_range(99);
            ms_now += $urandom_range(40);
            us_now += $urandom_range(40000);
            if (pick < 50) begin
                it = make_item(($urandom_range(1) != 0) ? OP_ARM_US : OP_ARM_MS,
                               5'($urandom), 32'($urandom_range(100)), 1'($urandom),
                               ms_now, us_now);
                if ($urandom_range(9) == 0) it.delay = $urandom;
                if (it.op == OP_ARM_US && $urandom_range(1)) it.delay = $urandom_range(200000);
            end else if (pick < 75) begin
                it = make_item(OP_EXPIRE, 5'($urandom), $urandom, 1'($urandom), ms_now, us_now);
            end else begin
                it = make_item(OP_QUERY, 5'($urandom), $urandom, 1'($urandom), ms_now, us_now);
                if ($urandom_range(1)) it.delay = $urandom_range(300);
            end
            // occasional jumps of the time fields
            if ($urandom_range(19) == 0) begin
                it.now_msec = $urandom;
                it.now_usec = {$urandom, $urandom};
            end
            send_item(it);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d input transactions and %0d results, %0d of them expirations",
                 n_items, n_results, n_expired);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("deadline_timer_queue_tb passed");
        end else begin
            $display("deadline_timer_queue_tb failed");
        end
        $finish;
    end

endmodule
